>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> rtl/core/ord_pkg.sv
package ord_pkg;

    localparam int DEPTH = 16;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef logic [PTR_W-1:0] ptr_t;

    localparam logic [1:0] ACT_INS_FRONT = 2'd0;
    localparam logic [1:0] ACT_INS_REAR  = 2'd1;
    localparam logic [1:0] ACT_REMOVE    = 2'd2;
    localparam logic [1:0] ACT_READOUT   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam ptr_t PTR_LAST = PTR_W'(DEPTH - 1);

    function automatic ptr_t wrap_inc(input ptr_t p);
        ptr_t r;
        if (p == PTR_LAST)
        begin
            r = '0;
        end
        else
        begin
            r = p + ptr_t'(1);
        end
        return r;
    endfunction

    function automatic ptr_t wrap_dec(input ptr_t p);
        ptr_t r;
        if (p == '0)
        begin
            r = PTR_LAST;
        end
        else
        begin
            r = p - ptr_t'(1);
        end
        return r;
    endfunction

endpackage

>>> rtl/core/output_restricted_deque_top.sv
// Channel   Direction  tdata            tuser         tlast
// s_axis    in         data_value[31:0] action[1:0]   unused
// m_axis    out        out_value[31:0]  status[1:0]   last_result
//
// An insert, or any request that fails, presents its result in the cycle after it is accepted.
// A remove first accepts the request and reads the front entry, then presents it once the result slot is free.
// A readout reads the stored entries from front to rear, one at a time, through the single memory read port.
// Reset clears the pointers and sets the empty flag; the entry memory is not cleared.
// A stalled result holds the block; no new request is taken until the result slot is free.
`include "assert_macros.svh"

module output_restricted_deque_top
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic signed [31:0]   s_axis_tdata,   // data_value[31:0]
    input  logic [1:0]           s_axis_tuser,   // action[1:0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic signed [31:0]   m_axis_tdata,   // out_value[31:0]
    output logic [1:0]           m_axis_tuser,   // status[1:0]
    output logic                 m_axis_tlast    // last_result
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic state_reg, state_next;
    logic walk_all_reg, walk_all_next;
    ord_pkg::ptr_t head_reg, head_next;
    ord_pkg::ptr_t tail_reg, tail_next;
    ord_pkg::ptr_t walk_reg, walk_next;
    logic empty_reg, empty_next;

    logic out_valid_reg, out_valid_next;
    logic signed [31:0] out_value_reg, out_value_next;
    logic [1:0] out_status_reg, out_status_next;
    logic out_last_reg, out_last_next;

    logic signed [31:0] mem [ord_pkg::DEPTH];
    logic signed [31:0] rd_data_reg;
    logic mem_we;
    ord_pkg::ptr_t wr_addr;
    logic rd_en;
    ord_pkg::ptr_t rd_addr;

    logic out_free;
    logic accept;
    logic full;
    logic walk_last;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign full = !empty_reg && (ord_pkg::wrap_inc(tail_reg) == head_reg);
    assign walk_last = !walk_all_reg || (walk_reg == tail_reg);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_value_reg;
    assign m_axis_tuser = out_status_reg;
    assign m_axis_tlast = out_last_reg;

    always_comb
    begin
        state_next = state_reg;
        walk_all_next = walk_all_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        walk_next = walk_reg;
        empty_next = empty_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_value_next = out_value_reg;
        out_status_next = out_status_reg;
        out_last_next = out_last_reg;
        mem_we = 1'b0;
        wr_addr = '0;
        rd_en = 1'b0;
        rd_addr = head_reg;

        if (accept)
        begin
            unique case (s_axis_tuser) inside
                ord_pkg::ACT_INS_FRONT, ord_pkg::ACT_INS_REAR:
                begin
                    out_valid_next = 1'b1;
                    out_value_next = '0;
                    out_last_next = 1'b1;
                    if (full)
                    begin
                        out_status_next = ord_pkg::ST_FULL;
                    end
                    else
                    begin
                        out_status_next = ord_pkg::ST_OK;
                        mem_we = 1'b1;
                        if (empty_reg)
                        begin
                            head_next = '0;
                            tail_next = '0;
                            empty_next = 1'b0;
                            wr_addr = '0;
                        end
                        else if (s_axis_tuser == ord_pkg::ACT_INS_FRONT)
                        begin
                            head_next = ord_pkg::wrap_dec(head_reg);
                            wr_addr = ord_pkg::wrap_dec(head_reg);
                        end
                        else
                        begin
                            tail_next = ord_pkg::wrap_inc(tail_reg);
                            wr_addr = ord_pkg::wrap_inc(tail_reg);
                        end
                    end
                end
                ord_pkg::ACT_REMOVE, ord_pkg::ACT_READOUT:
                begin
                    if (empty_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = '0;
                        out_status_next = ord_pkg::ST_EMPTY;
                        out_last_next = 1'b1;
                    end
                    else
                    begin
                        rd_en = 1'b1;
                        rd_addr = head_reg;
                        walk_next = head_reg;
                        state_next = ST_WALK;
                        walk_all_next = (s_axis_tuser == ord_pkg::ACT_READOUT);
                        if (s_axis_tuser == ord_pkg::ACT_REMOVE)
                        begin
                            if (head_reg == tail_reg)
                            begin
                                head_next = '0;
                                tail_next = '0;
                                empty_next = 1'b1;
                            end
                            else
                            begin
                                head_next = ord_pkg::wrap_inc(head_reg);
                            end
                        end
                    end
                end
                default:
                begin
                    out_valid_next = out_valid_reg && !m_axis_tready;
                end
            endcase
        end
        else if ((state_reg == ST_WALK) && out_free)
        begin
            out_valid_next = 1'b1;
            out_value_next = rd_data_reg;
            out_status_next = ord_pkg::ST_OK;
            out_last_next = walk_last;
            if (walk_last)
            begin
                state_next = ST_IDLE;
            end
            else
            begin
                rd_en = 1'b1;
                rd_addr = ord_pkg::wrap_inc(walk_reg);
                walk_next = ord_pkg::wrap_inc(walk_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            walk_all_reg <= 1'b0;
            head_reg <= '0;
            tail_reg <= '0;
            walk_reg <= '0;
            empty_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            walk_all_reg <= walk_all_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            walk_reg <= walk_next;
            empty_reg <= empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_status_reg <= out_status_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= s_axis_tdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    `ASSERT_PROP(a_empty_ptrs, clk, rst_n, empty_reg |-> (head_reg == '0 && tail_reg == '0))
    `ASSERT_NEVER(a_no_write_in_walk, clk, rst_n, (state_reg == ST_WALK) && mem_we)
    `ASSERT_PROP(a_request_answered, clk, rst_n, accept |=> (state_reg == ST_WALK || out_valid_reg))
    `ASSERT_NEVER(a_no_read_on_insert, clk, rst_n, mem_we && rd_en)

endmodule
